// ----- sv/bqd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants of the biquad direct form II filter.
package bqd_pkg;

   // Field and storage widths.
   localparam int SAMPLE_W    = 16;
   localparam int COEF_WIDTH  = 32;
   localparam int STATE_WIDTH = 48;
   localparam int COEF_FRAC   = COEF_WIDTH - 4;
   localparam int STATE_FRAC  = 16;

   // The MAC consumes one coefficient digit per cycle; the digit is as wide as
   // the integer part of the coefficient, so the fractional shift is a whole
   // number of digits.
   localparam int DIGIT_W = COEF_WIDTH - COEF_FRAC;
   localparam int DIGITS  = COEF_WIDTH / DIGIT_W;
   localparam int CNT_W   = $clog2(DIGITS);
   localparam int TERMS   = 3;
   localparam int ACC_W   = STATE_WIDTH + 8;

   // Register port geometry.
   localparam int REG_COUNT  = 5;
   localparam int DATA_W     = (COEF_WIDTH > 32) ? 64 : 32;
   localparam int REG_STRIDE = DATA_W / 8;
   localparam int IDX_LSB    = $clog2(REG_STRIDE);
   localparam int ADDR_W     = $clog2(REG_STRIDE * REG_COUNT);
   localparam int REG_IDX_W  = ADDR_W - IDX_LSB;

   typedef logic signed [SAMPLE_W-1:0]    sample_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic signed [STATE_WIDTH-1:0] delay_type;
   typedef logic signed [ACC_W-1:0]       acc_type;

   // Reset value of a0 is 1.0 in the coefficient format.
   localparam coef_type A0_RESET = coef_type'({{(COEF_WIDTH-1){1'b0}}, 1'b1} << COEF_FRAC);

   // Half of one digit weight, used to round the feedback sum.
   localparam acc_type HALF_DIGIT = acc_type'(1) <<< (DIGIT_W - 1);
   // Half of one output step, used to round the output sum.
   localparam acc_type HALF_OUT   = acc_type'(1) <<< (STATE_FRAC - 1);

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam delay_type  DELAY_MAX  = {1'b0, {(STATE_WIDTH-1){1'b1}}};
   localparam delay_type  DELAY_MIN  = {1'b1, {(STATE_WIDTH-1){1'b0}}};

   // Register indexes.
   typedef enum logic [REG_IDX_W-1:0] {
      REG_NEG_B1 = 0,
      REG_NEG_B2 = 1,
      REG_A0     = 2,
      REG_A1     = 3,
      REG_A2     = 4
   } reg_index_type;

   typedef struct packed {
      coef_type neg_b1;
      coef_type neg_b2;
      coef_type a0;
      coef_type a1;
      coef_type a2;
   } coef_set_type;

   // Command from the sequencer to the digit-serial MAC.
   typedef struct packed {
      logic start;
      logic round_half;
   } mac_cmd_type;

endpackage

// ----- sv/bqd_if.sv -----
`timescale 1ns / 1ps
// Handshake interfaces for the sample channel and the result channel.
interface bqd_req_if;
   import bqd_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bqd_rsp_if;
   import bqd_pkg::*;
   logic       valid;
   logic       ready;
   sample_type filtered;
   logic       clipped;

   modport source (output valid, output filtered, output clipped, input ready);
   modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

// ----- sv/biquad_iir_direct_form_two_unit.sv -----
`timescale 1ns / 1ps
// Biquad IIR section in direct form II: one 16-bit sample in, one rounded and
// saturated 16-bit result with a clip flag out. Coefficients are signed Q4.28
// set through the register port; the two delays are Q32.16 and saturate. A
// shared three-term MAC consumes one 4-bit coefficient digit per cycle, first for
// the feedback sum and then for the output sum; a sample is accepted only while
// no other is in either pass. The result sits in an output register, so a new
// sample is taken while the previous result waits; the next result only waits
// for that register to drain. Coefficients must be written only while no sample
// is in flight; the unit itself does not enforce this.
module biquad_iir_direct_form_two_unit (
   input  logic                       clock,
   input  logic                       reset,
   bqd_req_if.sink                    req,
   bqd_rsp_if.source                  rsp,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [bqd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [bqd_pkg::DATA_W-1:0] csr_pwdata,
   output logic [bqd_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import bqd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_FEEDBACK = 4'b0010,
      ST_LAUNCH   = 4'b0100,
      ST_FORWARD  = 4'b1000
   } fsm_type;

   fsm_type    state_ff, state_in;
   sample_type x_ff, x_in;
   delay_type  w_ff, w_in;
   delay_type  w1_ff, w1_in;
   delay_type  w2_ff, w2_in;
   logic       out_valid_ff, out_valid_in;
   sample_type filtered_ff, filtered_in;
   logic       clipped_ff, clipped_in;

   coef_set_type coefs;
   mac_cmd_type  mac_cmd;
   coef_type     mac_coef  [TERMS];
   delay_type    mac_mcand [TERMS];
   logic         mac_done;
   acc_type      mac_acc;

   logic                          accept;
   logic                          fb_phase;
   logic                          out_free;
   acc_type                       wsum;
   logic [ACC_W-STATE_WIDTH:0]    w_top;
   delay_type                     w_sat;
   acc_type                       ysum;
   logic signed [ACC_W-STATE_FRAC-1:0] y_round;
   logic [ACC_W-STATE_FRAC-SAMPLE_W:0] y_top;
   logic                          y_fits;
   sample_type                    y_sat;

   bqd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coefs       (coefs)
   );

   bqd_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .coef  (mac_coef),
      .mcand (mac_mcand),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   assign req.ready    = (state_ff == ST_IDLE);
   assign accept       = req.valid && req.ready;
   assign fb_phase     = (state_ff == ST_IDLE) || (state_ff == ST_FEEDBACK);
   assign out_free     = !out_valid_ff || rsp.ready;
   assign rsp.valid    = out_valid_ff;
   assign rsp.filtered = filtered_ff;
   assign rsp.clipped  = clipped_ff;

   // MAC operands: the feedback pass uses the delays and the negated poles,
   // the output pass the new intermediate and the delays before the update.
   always_comb begin
      if (fb_phase) begin
         mac_coef[0]  = coefs.neg_b1;
         mac_coef[1]  = coefs.neg_b2;
         mac_coef[2]  = '0;
         mac_mcand[0] = w1_ff;
         mac_mcand[1] = w2_ff;
         mac_mcand[2] = '0;
      end else begin
         mac_coef[0]  = coefs.a0;
         mac_coef[1]  = coefs.a1;
         mac_coef[2]  = coefs.a2;
         mac_mcand[0] = w_ff;
         mac_mcand[1] = w1_ff;
         mac_mcand[2] = w2_ff;
      end
      mac_cmd.start      = accept || (state_ff == ST_LAUNCH);
      mac_cmd.round_half = (state_ff == ST_IDLE);
   end

   // New intermediate: rounded feedback sum plus the sample, saturated.
   always_comb begin
      wsum  = mac_acc + (acc_type'(x_ff) <<< STATE_FRAC);
      w_top = wsum[ACC_W-1:STATE_WIDTH-1];
      if ((&w_top) || !(|w_top)) begin
         w_sat = wsum[STATE_WIDTH-1:0];
      end else begin
         w_sat = wsum[ACC_W-1] ? DELAY_MIN : DELAY_MAX;
      end
   end

   // Output: drop the delay fraction with round half up, then saturate.
   always_comb begin
      ysum    = mac_acc + HALF_OUT;
      y_round = ysum[ACC_W-1:STATE_FRAC];
      y_top   = y_round[ACC_W-STATE_FRAC-1:SAMPLE_W-1];
      y_fits  = (&y_top) || !(|y_top);
      if (y_fits) begin
         y_sat = y_round[SAMPLE_W-1:0];
      end else begin
         y_sat = y_round[ACC_W-STATE_FRAC-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      w_in         = w_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      filtered_in  = filtered_ff;
      clipped_in   = clipped_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in     = req.sample;
               state_in = ST_FEEDBACK;
            end
         end
         ST_FEEDBACK: begin
            if (mac_done) begin
               w_in     = w_sat;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_FORWARD;
         end
         ST_FORWARD: begin
            if (mac_done && out_free) begin
               filtered_in  = y_sat;
               clipped_in   = !y_fits;
               out_valid_in = 1'b1;
               w2_in        = w1_ff;
               w1_in        = w_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         w1_ff        <= '0;
         w2_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w1_ff        <= w1_in;
         w2_ff        <= w2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      w_ff        <= w_in;
      filtered_ff <= filtered_in;
      clipped_ff  <= clipped_in;
   end

endmodule

// ----- sv/bqd_csr.sv -----
`timescale 1ns / 1ps
// APB-style register file holding the five filter coefficients.
module bqd_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [bqd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [bqd_pkg::DATA_W-1:0] csr_pwdata,
   output logic [bqd_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output bqd_pkg::coef_set_type      coefs
);
   import bqd_pkg::*;

   coef_set_type  coefs_ff, coefs_in;
   reg_index_type reg_idx;
   coef_type      wr_value;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_index_type'(csr_paddr[ADDR_W-1:IDX_LSB]);
   assign wr_value   = csr_pwdata[COEF_WIDTH-1:0];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign coefs      = coefs_ff;

   // Write decode; indexes past the last register are dropped.
   always_comb begin
      coefs_in = coefs_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_NEG_B1: coefs_in.neg_b1 = wr_value;
            REG_NEG_B2: coefs_in.neg_b2 = wr_value;
            REG_A0:     coefs_in.a0     = wr_value;
            REG_A1:     coefs_in.a1     = wr_value;
            REG_A2:     coefs_in.a2     = wr_value;
            default:    coefs_in        = coefs_ff;
         endcase
      end
   end

   // Read decode, sign-extended to the bus width.
   always_comb begin
      unique case (reg_idx)
         REG_NEG_B1: csr_prdata = DATA_W'(coefs_ff.neg_b1);
         REG_NEG_B2: csr_prdata = DATA_W'(coefs_ff.neg_b2);
         REG_A0:     csr_prdata = DATA_W'(coefs_ff.a0);
         REG_A1:     csr_prdata = DATA_W'(coefs_ff.a1);
         REG_A2:     csr_prdata = DATA_W'(coefs_ff.a2);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.neg_b1 <= '0;
         coefs_ff.neg_b2 <= '0;
         coefs_ff.a0     <= A0_RESET;
         coefs_ff.a1     <= '0;
         coefs_ff.a2     <= '0;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

endmodule

// ----- sv/bqd_mac.sv -----
`timescale 1ns / 1ps
// Digit-serial three-term multiply-accumulate with a built-in fractional shift.
module bqd_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  bqd_pkg::mac_cmd_type cmd,
   input  bqd_pkg::coef_type    coef  [bqd_pkg::TERMS],
   input  bqd_pkg::delay_type   mcand [bqd_pkg::TERMS],
   output logic                 done,
   output bqd_pkg::acc_type     acc
);
   import bqd_pkg::*;

   logic [COEF_WIDTH-1:0] coef_sr_ff [TERMS];
   logic [COEF_WIDTH-1:0] coef_sr_in [TERMS];
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  round_ff, round_in;
   acc_type               acc_ff, acc_in;

   logic signed [DIGIT_W:0]             digit [TERMS];
   logic signed [STATE_WIDTH+DIGIT_W:0] prod  [TERMS];
   acc_type                             sum;
   logic                                last;

   assign done = done_ff;
   assign acc  = acc_ff;
   assign last = (cnt_ff == CNT_W'(DIGITS - 1));

   // One coefficient digit per term, least significant first. The top digit
   // carries the sign; the others are unsigned.
   always_comb begin
      sum = acc_ff;
      for (int i = 0; i < TERMS; i++) begin
         digit[i] = last ? {coef_sr_ff[i][DIGIT_W-1], coef_sr_ff[i][DIGIT_W-1:0]}
                         : {1'b0, coef_sr_ff[i][DIGIT_W-1:0]};
         prod[i]  = digit[i] * mcand[i];
         sum      = sum + acc_type'(prod[i]);
      end
      // The rounding half of the fractional shift lands in the next to last digit.
      if (round_ff && (cnt_ff == CNT_W'(DIGITS - 2))) begin
         sum = sum + HALF_DIGIT;
      end
   end

   // The accumulator shifts right one digit after every digit but the last,
   // so it ends at the sum floored by the coefficient fraction.
   always_comb begin
      coef_sr_in = coef_sr_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = done_ff;
      round_in   = round_ff;
      acc_in     = acc_ff;
      if (cmd.start) begin
         for (int i = 0; i < TERMS; i++) begin
            coef_sr_in[i] = coef[i];
         end
         cnt_in   = '0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
         round_in = cmd.round_half;
         acc_in   = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < TERMS; i++) begin
            coef_sr_in[i] = coef_sr_ff[i] >> DIGIT_W;
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            acc_in  = sum;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = sum >>> DIGIT_W;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_sr_ff <= coef_sr_in;
      round_ff   <= round_in;
      acc_ff     <= acc_in;
   end

endmodule

// ----- sv/bqd_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the biquad unit and the bind that attaches them.
module bqd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bqd_pkg::sample_type rsp_filtered,
   input logic                rsp_clipped
);
   import bqd_pkg::*;

   // Reset leaves no result pending and the input open.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result pending or input closed after reset");

   // An accepted item leaves the input closed after it is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input open right after an item was accepted");

   // A clipped result sits at one end of the output range.
   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_filtered == SAMPLE_MAX || rsp_filtered == SAMPLE_MIN))
      else $error("clipped result not at a rail");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_filtered) && $stable(rsp_clipped)))
      else $error("stalled result changed");

endmodule

bind biquad_iir_direct_form_two_unit bqd_checker u_bqd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_filtered (rsp.filtered),
   .rsp_clipped  (rsp.clipped)
);

// ----- tb/sv/tb_biquad_iir_direct_form_two_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the biquad direct form II unit against an in-bench filter model.
module tb_biquad_iir_direct_form_two_unit;
   import bqd_pkg::*;

   localparam int ACC_FRAC       = COEF_FRAC + STATE_FRAC;
   localparam int BAD_INDEX_LO   = REG_COUNT;
   localparam int BAD_INDEX_HI   = (1 << REG_IDX_W) - 1;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 85;
   localparam int HOLD_OFF_ITEM  = 41;
   localparam int TAIL_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_ROWS  = 36;

   localparam coef_type COEF_MAX       = coef_type'({1'b0, {(COEF_WIDTH-1){1'b1}}});
   localparam coef_type COEF_MIN       = coef_type'({1'b1, {(COEF_WIDTH-1){1'b0}}});
   localparam coef_type COEF_MINUS_ONE = coef_type'(-A0_RESET);

   typedef logic signed [127:0] wide_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {COEF_STABLE, COEF_FULL, COEF_EXTREME} coef_mode_type;

   // One row of the directed table: a sample item or a register write.
   typedef struct {
      row_kind_type kind;
      int           index;
      logic [31:0]  value;
      logic         typed;
      sample_type   filtered;
      logic         clipped;
   } stim_row_type;

   typedef struct {
      sample_type sample_in;
      sample_type filtered;
      logic       clipped;
   } filter_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;

   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   bqd_req_if sample_ch ();
   bqd_rsp_if result_ch ();

   // Filter model state: coefficient copy and the two delays.
   coef_type  coef_bank [REG_COUNT];
   delay_type delay_newest;
   delay_type delay_oldest;

   filter_result_type pending_outputs [$];
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // Reset coefficients pass the sample straight through.
      '{ROW_SAMPLE, 0, 32'h0000_0000, 1'b1, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b1, 16'h7FFF, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_8000, 1'b1, 16'h8000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_0001, 1'b1, 16'h0001, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_FFFF, 1'b1, 16'hFFFF, 1'b0},
      // Largest positive gain clips both extremes.
      '{ROW_WRITE, int'(REG_A0), 32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b1, 16'h7FFF, 1'b1},
      '{ROW_SAMPLE, 0, 32'h0000_8000, 1'b1, 16'h8000, 1'b1},
      // Gain of minus eight flips and clips.
      '{ROW_WRITE, int'(REG_A0), 32'h8000_0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b1, 16'h8000, 1'b1},
      '{ROW_SAMPLE, 0, 32'h0000_8000, 1'b1, 16'h7FFF, 1'b1},
      // Gain of one half: halves round upward.
      '{ROW_WRITE, int'(REG_A0), 32'h0800_0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_0001, 1'b1, 16'h0001, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_FFFF, 1'b1, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_0003, 1'b1, 16'h0002, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_FFFD, 1'b1, 16'hFFFF, 1'b0},
      // Writes beyond the last register change nothing.
      '{ROW_WRITE, BAD_INDEX_LO, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, BAD_INDEX_HI, 32'h1234_5678, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_0005, 1'b1, 16'h0003, 1'b0},
      // Unstable extreme coefficients drive the delays into saturation.
      '{ROW_WRITE, int'(REG_NEG_B1), 32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, int'(REG_NEG_B2), 32'h8000_0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, int'(REG_A1), 32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, int'(REG_A2), 32'h8000_0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, int'(REG_A0), 32'h1000_0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, int'(REG_NEG_B1), 32'h8000_0000, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_8000, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_8000, 1'b0, 16'h0000, 1'b0},
      '{ROW_SAMPLE, 0, 32'h0000_8000, 1'b0, 16'h0000, 1'b0}
   };

   biquad_iir_direct_form_two_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req         (sample_ch),
      .rsp         (result_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model of one filter step; updates the delays and returns the expected output.
   function automatic void filter_step(input sample_type x, output sample_type y,
                                       output logic clip);
      wide_type coef_w [REG_COUNT];
      wide_type w1, w2, w_new, sum;
      w1 = wide_type'(delay_newest);
      w2 = wide_type'(delay_oldest);
      for (int i = 0; i < REG_COUNT; i++) coef_w[i] = wide_type'(coef_bank[i]);

      // Feedback sum, rounded half up to the delay format and saturated.
      sum = (wide_type'(x) <<< ACC_FRAC) + coef_w[REG_NEG_B1] * w1 + coef_w[REG_NEG_B2] * w2;
      sum = (sum + (wide_type'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (sum > wide_type'(DELAY_MAX)) w_new = wide_type'(DELAY_MAX);
      else if (sum < wide_type'(DELAY_MIN)) w_new = wide_type'(DELAY_MIN);
      else w_new = sum;

      // Output sum uses the new intermediate and the old delays.
      sum = coef_w[REG_A0] * w_new + coef_w[REG_A1] * w1 + coef_w[REG_A2] * w2;
      sum = (sum + (wide_type'(1) <<< (ACC_FRAC - 1))) >>> ACC_FRAC;
      clip = 1'b1;
      if (sum > wide_type'(SAMPLE_MAX)) y = SAMPLE_MAX;
      else if (sum < wide_type'(SAMPLE_MIN)) y = SAMPLE_MIN;
      else begin
         y    = sample_type'(sum);
         clip = 1'b0;
      end

      delay_oldest = delay_newest;
      delay_newest = delay_type'(w_new);
   endfunction

   // Idle length: mostly none or short, now and then long; none in calm phases.
   function automatic int idle_gap();
      int r;
      if (calm) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 50) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   function automatic coef_type extreme_coef();
      case ($urandom_range(0, 4))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return A0_RESET;
         3: return COEF_MINUS_ONE;
         default: return coef_type'(0);
      endcase
   endfunction

   // Random samples: repeats give step runs, plus extremes, small values and full range.
   function automatic sample_type next_sample(input sample_type last_value);
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 15) return last_value;
      if (r < 25) begin
         case ($urandom_range(0, 4))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return sample_type'(1);
            3: return sample_type'(-1);
            default: return sample_type'(0);
         endcase
      end
      if (r < 55) return sample_type'(int'($urandom_range(0, 512)) - 256);
      return sample_type'($urandom());
   endfunction

   // One register port transfer; starts and ends at a falling edge.
   task automatic csr_transfer(input int idx, input logic is_write,
                               input logic [DATA_W-1:0] wdata,
                               output logic [DATA_W-1:0] rdata);
      csr_psel   = 1'b1;
      csr_pwrite = is_write;
      csr_paddr  = ADDR_W'(idx * REG_STRIDE);
      csr_pwdata = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_penable = 1'b0;
   endtask

   task automatic csr_release();
      csr_psel   = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic verify_register(input int idx);
      logic [DATA_W-1:0] rdata;
      csr_transfer(idx, 1'b0, '0, rdata);
      if (coef_type'(rdata) !== coef_bank[idx]) begin
         $display("%0t: register %0d read mismatch: expected %h, got %h",
                  $time, idx, coef_bank[idx], rdata);
         mismatch_count++;
      end
   endtask

   // Write a register; for a valid index, mirror it in the model and read it back.
   task automatic program_register(input int idx, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] rdata;
      csr_transfer(idx, 1'b1, value, rdata);
      if (idx < REG_COUNT) begin
         coef_bank[idx] = coef_type'(value);
         verify_register(idx);
      end
   endtask

   // Offer one sample item; the expectation is queued when the item is taken.
   task automatic send_sample(input sample_type x, input logic typed,
                              input sample_type typed_filtered, input logic typed_clipped,
                              input int gap_after);
      sample_type y;
      logic       clip;
      sample_ch.valid  = 1'b1;
      sample_ch.sample = x;
      @(posedge clock);
      while (!sample_ch.ready) @(posedge clock);
      filter_step(x, y, clip);
      if (typed) begin
         y    = typed_filtered;
         clip = typed_clipped;
      end
      pending_outputs.push_back('{x, y, clip});
      @(negedge clock);
      if (gap_after > 0) begin
         sample_ch.valid = 1'b0;
         repeat (gap_after) @(negedge clock);
      end
   endtask

   task automatic drain_outputs();
      while (pending_outputs.size() != 0) @(negedge clock);
   endtask

   // New coefficient set: stable, full-range random or extreme values.
   task automatic load_coefficients(input coef_mode_type mode);
      coef_type fresh [REG_COUNT];
      int nb2, lim;
      case (mode)
         COEF_STABLE: begin
            // Poles kept inside the stability triangle, gains of magnitude at most one.
            nb2 = int'($urandom_range(0, 480000000)) - 240000000;
            lim = (268435456 - nb2) / 10 * 9;
            fresh[REG_NEG_B2] = coef_type'(nb2);
            fresh[REG_NEG_B1] = coef_type'(int'($urandom_range(0, 2 * lim)) - lim);
            fresh[REG_A0] = coef_type'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
            fresh[REG_A1] = coef_type'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
            fresh[REG_A2] = coef_type'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
         end
         COEF_FULL: begin
            for (int i = 0; i < REG_COUNT; i++) fresh[i] = coef_type'($urandom());
         end
         default: begin
            for (int i = 0; i < REG_COUNT; i++) fresh[i] = extreme_coef();
         end
      endcase
      for (int i = 0; i < REG_COUNT; i++) program_register(i, DATA_W'(fresh[i]));
      program_register(int'($urandom_range(BAD_INDEX_LO, BAD_INDEX_HI)), DATA_W'($urandom()));
      csr_release();
   endtask

   // Result receiver: random stalls, none in calm phases.
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      result_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            result_ch.ready = 1'b0;
            stall_left = stall_left - 1;
         end else begin
            result_ch.ready = 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = idle_gap();
         end
      end
   end

   // Compare each output item with the oldest expectation.
   always @(posedge clock) begin
      filter_result_type want;
      if (!reset && result_ch.valid && result_ch.ready) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected output %0d clip %0b", $time,
                     result_ch.filtered, result_ch.clipped);
            mismatch_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (result_ch.filtered !== want.filtered || result_ch.clipped !== want.clipped) begin
               $display("%0t: output mismatch for sample %0d: expected %0d clip %0b, got %0d clip %0b",
                        $time, want.sample_in, want.filtered, want.clipped,
                        result_ch.filtered, result_ch.clipped);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no item and no register access is taken.
   always @(posedge clock) begin
      if (reset || (sample_ch.valid && sample_ch.ready) ||
          (result_ch.valid && result_ch.ready) || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_biquad_iir_direct_form_two_unit: done, errors");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed table, random phases, drain and verdict.
   initial begin : stimulus
      stim_row_type  row;
      coef_mode_type mode;
      sample_type    last_value;
      int            gap;
      logic          ends_run;

      sample_ch.valid  = 1'b0;
      sample_ch.sample = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      last_value  = '0;
      for (int i = 0; i < REG_COUNT; i++) coef_bank[i] = coef_type'(0);
      coef_bank[REG_A0] = A0_RESET;
      delay_newest = '0;
      delay_oldest = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Registers hold their reset values.
      for (int i = 0; i < REG_COUNT; i++) verify_register(i);
      csr_release();

      // Directed table.
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_rows[n];
         if (row.kind == ROW_WRITE) begin
            drain_outputs();
            program_register(row.index, row.value);
         end else begin
            csr_release();
            ends_run = (n + 1 == DIRECTED_ROWS) || (directed_rows[n + 1].kind == ROW_WRITE);
            gap = idle_gap() + (ends_run ? 1 : 0);
            send_sample(sample_type'(row.value[15:0]), row.typed, row.filtered, row.clipped,
                        gap);
         end
      end

      // Random phases, each with a fresh coefficient set.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_outputs();
         calm = (phase % 4 == 1);
         case (phase)
            0: mode = COEF_STABLE;
            1: mode = COEF_EXTREME;
            2: mode = COEF_FULL;
            default: begin
               gap  = int'($urandom_range(0, 9));
               mode = (gap < 6) ? COEF_STABLE : (gap < 8) ? COEF_FULL : COEF_EXTREME;
            end
         endcase
         load_coefficients(mode);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            last_value = next_sample(last_value);
            gap = idle_gap();
            if (k == HOLD_OFF_ITEM || k == PHASE_ITEMS - 1) gap = gap + 1;
            send_sample(last_value, 1'b0, '0, 1'b0, gap);
            // Hold off the sender until every output has come back.
            if (k == HOLD_OFF_ITEM) drain_outputs();
         end
      end

      drain_outputs();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_biquad_iir_direct_form_two_unit: done, clean");
      end else begin
         $display("tb_biquad_iir_direct_form_two_unit: done, errors");
      end
      $finish;
   end

endmodule
